>>> src/pss_pkg.sv
// Shared widths, codes and control types of the process slice scheduler.
`default_nettype none
package pss_pkg;

  localparam int DEF_MAX_PROCS = 8;
  localparam int REQ_W   = 2;
  localparam int ARR_W   = 16;
  localparam int BURST_W = 12;
  localparam int PRIO_W  = 8;
  localparam int TIME_W  = 17;
  localparam int STAT_W  = 2;
  localparam int IDX_W   = 3;
  localparam int MODE_W  = 3;
  localparam int QNT_W   = 12;
  localparam int CFG_W   = 1;
  localparam int CFG_D_W = 12;

  localparam logic [TIME_W-1:0] TIME_LIMIT = 17'h1FFFF;
  localparam logic [PRIO_W-1:0] PRIO_MIN   = 8'h80;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
  localparam logic [REQ_W-1:0] REQ_STEP  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  localparam logic [STAT_W-1:0] ST_SLICE = 2'd0;
  localparam logic [STAT_W-1:0] ST_OK    = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd3;

  localparam logic [MODE_W-1:0] MODE_FCFS  = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SJF   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_SRTF  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RR    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_SPRIO = 3'd4;
  localparam logic [MODE_W-1:0] MODE_DPRIO = 3'd5;

  localparam logic [CFG_W-1:0] REG_MODE    = 1'd0;
  localparam logic [CFG_W-1:0] REG_QUANTUM = 1'd1;

  typedef struct packed {
    logic accept;
    logic load;
    logic clear;
    logic none_left;
    logic scan_start;
    logic scan1;
    logic decide;
    logic scan2;
    logic update;
  } pss_cmd_t;

  typedef struct packed {
    logic [REQ_W-1:0] req_type;
    logic             empty;
    logic             last;
    logic             any_left;
  } pss_stat_t;

endpackage
`default_nettype wire

>>> src/pss_req_if.sv
// Request channel: valid, ready and one request beat.
`default_nettype none
interface pss_req_if;
  logic                           valid;
  logic                           ready;
  logic [pss_pkg::REQ_W-1:0]      req_type;
  logic [pss_pkg::ARR_W-1:0]      arrival;
  logic [pss_pkg::BURST_W-1:0]    burst;
  logic signed [pss_pkg::PRIO_W-1:0] priority_req;
  modport source (output valid, req_type, arrival, burst, priority_req, input ready);
  modport sink (input valid, req_type, arrival, burst, priority_req, output ready);
endinterface
`default_nettype wire

>>> src/pss_res_if.sv
// Result channel: valid, ready and one slice beat.
`default_nettype none
interface pss_res_if;
  logic                         valid;
  logic                         ready;
  logic [pss_pkg::STAT_W-1:0]   status;
  logic [pss_pkg::IDX_W-1:0]    proc_index;
  logic [pss_pkg::TIME_W-1:0]   start_time;
  logic [pss_pkg::TIME_W-1:0]   end_time;
  logic                         completed;
  logic [pss_pkg::TIME_W-1:0]   turnaround;
  logic [pss_pkg::TIME_W-1:0]   waiting;
  modport source (output valid, status, proc_index, start_time, end_time, completed,
                  turnaround, waiting, input ready);
  modport sink (input valid, status, proc_index, start_time, end_time, completed,
                turnaround, waiting, output ready);
endinterface
`default_nettype wire

>>> src/pss_cfg_if.sv
// Configuration write channel: valid, ready, register index and data.
`default_nettype none
interface pss_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [pss_pkg::CFG_W-1:0]    index;
  logic [pss_pkg::CFG_D_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

>>> src/pss_datapath.sv
// Process table, scan registers, slice arithmetic and result register.
`default_nettype none
module pss_datapath #(
  parameter int MAX_PROCS = pss_pkg::DEF_MAX_PROCS
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire pss_pkg::pss_cmd_t      cmd,
  output pss_pkg::pss_stat_t          stat,
  pss_req_if.sink                     req,
  pss_res_if.source                   res,
  pss_cfg_if.sink                     cfg
);

  localparam int IW = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CW = $clog2(MAX_PROCS + 1);
  localparam int TW = pss_pkg::TIME_W;

  logic [pss_pkg::ARR_W-1:0]   arr_mem   [MAX_PROCS];
  logic [pss_pkg::BURST_W-1:0] burst_mem [MAX_PROCS];
  logic [pss_pkg::BURST_W-1:0] rem_mem   [MAX_PROCS];
  logic [pss_pkg::PRIO_W-1:0]  prio_mem  [MAX_PROCS];
  logic [TW-1:0]               rq_mem    [MAX_PROCS];
  logic [MAX_PROCS-1:0]        done;

  logic [CW-1:0]               count;
  logic [TW-1:0]               now;
  logic                        running;
  logic [pss_pkg::MODE_W-1:0]  mode;
  logic [pss_pkg::QNT_W-1:0]   quantum;

  logic [pss_pkg::REQ_W-1:0]   rq_type;
  logic [pss_pkg::ARR_W-1:0]   rq_arr;
  logic [pss_pkg::BURST_W-1:0] rq_burst;
  logic [pss_pkg::PRIO_W-1:0]  rq_prio;

  logic [IW-1:0]               idx;
  logic                        any_left;
  logic                        any_arr;
  logic [pss_pkg::ARR_W-1:0]   earliest;
  logic                        pick_vld;
  logic [IW-1:0]               pick;
  logic [TW-1:0]               best_key;

  logic [pss_pkg::STAT_W-1:0]  o_status;
  logic [pss_pkg::IDX_W-1:0]   o_index;
  logic [TW-1:0]               o_start;
  logic [TW-1:0]               o_end;
  logic                        o_done;
  logic [TW-1:0]               o_ta;
  logic [TW-1:0]               o_wait;

  logic [pss_pkg::MODE_W-1:0]  m;
  logic                        preempt;
  logic [pss_pkg::ARR_W-1:0]   e_arr;
  logic [pss_pkg::BURST_W-1:0] e_burst;
  logic [pss_pkg::BURST_W-1:0] e_rem;
  logic [pss_pkg::PRIO_W-1:0]  e_prio;
  logic [TW-1:0]               e_key;
  logic                        e_cand;
  logic [pss_pkg::QNT_W-1:0]   q;
  logic [pss_pkg::BURST_W-1:0] run;
  logic [TW:0]                 sum;
  logic [TW-1:0]               end_t;
  logic [pss_pkg::BURST_W-1:0] rem_next;
  logic [TW-1:0]               ta;
  logic [TW-1:0]               wait_t;

  assign cfg.ready = 1'b1;

  assign stat.req_type = rq_type;
  assign stat.empty    = (count == '0);
  assign stat.last     = ({{(CW > IW ? CW - IW : 1){1'b0}}, idx} == CW'(count - 1'b1)) ||
                         (count == '0);
  assign stat.any_left = any_left;

  always_comb begin
    m = (mode > pss_pkg::MODE_DPRIO) ? pss_pkg::MODE_FCFS : mode;
    preempt = m inside {pss_pkg::MODE_SRTF, pss_pkg::MODE_RR, pss_pkg::MODE_DPRIO};
    e_arr   = arr_mem[idx];
    e_burst = burst_mem[idx];
    e_rem   = rem_mem[idx];
    e_prio  = prio_mem[idx];
    // Smaller key wins in every mode; priority is flipped into that order.
    case (m)
      pss_pkg::MODE_SJF, pss_pkg::MODE_SRTF: e_key = TW'(e_rem);
      pss_pkg::MODE_RR: e_key = rq_mem[idx];
      pss_pkg::MODE_SPRIO, pss_pkg::MODE_DPRIO: e_key = TW'(~(e_prio ^ pss_pkg::PRIO_MIN));
      default: e_key = TW'(e_arr);
    endcase
    e_cand = !done[idx] && (TW'(e_arr) <= now);
    q   = (quantum == '0) ? pss_pkg::QNT_W'(1) : quantum;
    run = (preempt && e_rem > q) ? q : e_rem;
    sum = {1'b0, now} + (TW + 1)'(run);
    end_t = sum[TW] ? pss_pkg::TIME_LIMIT : sum[TW-1:0];
    rem_next = e_rem - run;
    ta = end_t - TW'(e_arr);
    wait_t = (ta > TW'(e_burst)) ? ta - TW'(e_burst) : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done     <= '0;
      count    <= '0;
      now      <= '0;
      running  <= 1'b0;
      mode     <= pss_pkg::MODE_FCFS;
      quantum  <= pss_pkg::QNT_W'(1);
      idx      <= '0;
      any_left <= 1'b0;
      any_arr  <= 1'b0;
      pick_vld <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.index)
          pss_pkg::REG_MODE:    mode <= cfg.data[pss_pkg::MODE_W-1:0];
          pss_pkg::REG_QUANTUM: quantum <= cfg.data;
          default: ;
        endcase
      end
      if (cmd.accept) begin
        rq_type  <= req.req_type;
        rq_arr   <= req.arrival;
        rq_burst <= req.burst;
        rq_prio  <= req.priority_req;
      end
      if (cmd.load) begin
        o_status <= (count >= CW'(MAX_PROCS)) ? pss_pkg::ST_FULL : pss_pkg::ST_OK;
        if (count < CW'(MAX_PROCS)) begin
          arr_mem[count[IW-1:0]]   <= rq_arr;
          burst_mem[count[IW-1:0]] <= rq_burst;
          rem_mem[count[IW-1:0]]   <= rq_burst;
          prio_mem[count[IW-1:0]]  <= rq_prio;
          rq_mem[count[IW-1:0]]    <= TW'(rq_arr);
          done[count[IW-1:0]]      <= 1'b0;
          count <= count + 1'b1;
        end
      end
      if (cmd.clear) begin
        done     <= '0;
        count    <= '0;
        now      <= '0;
        running  <= 1'b0;
        o_status <= pss_pkg::ST_OK;
      end
      if (cmd.none_left) begin
        o_status <= pss_pkg::ST_DONE;
      end
      if (cmd.load || cmd.clear || cmd.none_left) begin
        o_index <= '0;
        o_start <= '0;
        o_end   <= '0;
        o_done  <= 1'b0;
        o_ta    <= '0;
        o_wait  <= '0;
      end
      if (cmd.scan_start) begin
        idx      <= '0;
        any_left <= 1'b0;
        any_arr  <= 1'b0;
      end
      if (cmd.scan1) begin
        if (!done[idx]) begin
          if (!any_left || e_arr < earliest) begin
            earliest <= e_arr;
          end
          any_left <= 1'b1;
          if (TW'(e_arr) <= now) begin
            any_arr <= 1'b1;
          end
        end
        idx <= idx + 1'b1;
      end
      if (cmd.decide) begin
        // Jump over an idle gap, or start the clock at the first arrival.
        if (!running || !any_arr) begin
          now <= TW'(earliest);
        end
        running  <= 1'b1;
        idx      <= '0;
        pick_vld <= 1'b0;
      end
      if (cmd.scan2) begin
        if (e_cand && (!pick_vld || e_key < best_key)) begin
          pick_vld <= 1'b1;
          pick     <= idx;
          best_key <= e_key;
        end
        if (stat.last) begin
          idx <= (e_cand && (!pick_vld || e_key < best_key)) ? idx : pick;
        end else begin
          idx <= idx + 1'b1;
        end
      end
      if (cmd.update) begin
        now <= end_t;
        rem_mem[idx] <= rem_next;
        o_status <= pss_pkg::ST_SLICE;
        o_index  <= pss_pkg::IDX_W'(idx);
        o_start  <= now;
        o_end    <= end_t;
        if (rem_next == '0) begin
          done[idx] <= 1'b1;
          o_done <= 1'b1;
          o_ta   <= ta;
          o_wait <= wait_t;
        end else begin
          o_done <= 1'b0;
          o_ta   <= '0;
          o_wait <= '0;
          if (m == pss_pkg::MODE_RR) begin
            rq_mem[idx] <= end_t;
          end
          if (m == pss_pkg::MODE_DPRIO && e_prio != pss_pkg::PRIO_MIN) begin
            prio_mem[idx] <= e_prio - 1'b1;
          end
        end
      end
    end
  end

  assign res.status     = o_status;
  assign res.proc_index = o_index;
  assign res.start_time = o_start;
  assign res.end_time   = o_end;
  assign res.completed  = o_done;
  assign res.turnaround = o_ta;
  assign res.waiting    = o_wait;

endmodule
`default_nettype wire

>>> src/pss_ctrl.sv
// Sequencer for load, clear and the two-pass step scan.
`default_nettype none
module pss_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire pss_pkg::pss_stat_t  stat,
  output pss_pkg::pss_cmd_t        cmd,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready
);

  typedef enum logic [2:0] {
    S_IDLE, S_DISPATCH, S_SCAN1, S_DECIDE, S_SCAN2, S_UPDATE, S_OUT
  } state_t;

  state_t state;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE: cmd.accept = in_valid;
      S_DISPATCH: begin
        case (stat.req_type)
          pss_pkg::REQ_LOAD:  cmd.load = 1'b1;
          pss_pkg::REQ_CLEAR: cmd.clear = 1'b1;
          pss_pkg::REQ_STEP: begin
            cmd.scan_start = !stat.empty;
            cmd.none_left  = stat.empty;
          end
          default: ;
        endcase
      end
      S_SCAN1:  cmd.scan1 = 1'b1;
      S_DECIDE: begin
        cmd.decide    = stat.any_left;
        cmd.none_left = !stat.any_left;
      end
      S_SCAN2:  cmd.scan2 = 1'b1;
      S_UPDATE: cmd.update = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: if (in_valid) state <= S_DISPATCH;
        S_DISPATCH: begin
          case (stat.req_type)
            pss_pkg::REQ_LOAD, pss_pkg::REQ_CLEAR: state <= S_OUT;
            pss_pkg::REQ_STEP: state <= stat.empty ? S_OUT : S_SCAN1;
            default: state <= S_IDLE; // drop unassigned request types
          endcase
        end
        S_SCAN1:  if (stat.last) state <= S_DECIDE;
        S_DECIDE: state <= stat.any_left ? S_SCAN2 : S_OUT;
        S_SCAN2:  if (stat.last) state <= S_UPDATE;
        S_UPDATE: state <= S_OUT;
        S_OUT:    if (out_ready) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> src/process_slice_scheduler.sv
// Top level of the process slice scheduler.
// Channels: req (sink) carries load, step and clear requests; res (source)
// returns one beat per request (unassigned request types give none); cfg
// writes sched_mode (index 0) and quantum (index 1) and is always ready.
// One request is handled at a time: req is ready only while the block is
// idle, and stays low until the result beat has been taken.
// A load or clear goes from the dispatch state straight to the result. A
// step runs two passes over the table, one entry per cycle, through a
// single read port: the first finds the earliest pending arrival, the
// second picks the winner under the current mode; an update state then
// computes the slice. A step on an empty table skips both passes, and one
// in which every loaded process has finished ends after the first pass.
// Reset empties the table, zeroes the clock, sets fcfs and a quantum of 1.
// If res is stalled the result beat holds and no new request is taken.
`default_nettype none
module process_slice_scheduler #(
  parameter int MAX_PROCS = pss_pkg::DEF_MAX_PROCS
) (
  input wire logic   clk,
  input wire logic   rst,
  pss_req_if.sink    req,
  pss_res_if.source  res,
  pss_cfg_if.sink    cfg
);

  pss_pkg::pss_cmd_t  cmd;
  pss_pkg::pss_stat_t stat;

  pss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .stat      (stat),
    .cmd       (cmd),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (res.valid),
    .out_ready (res.ready)
  );

  pss_datapath #(.MAX_PROCS(MAX_PROCS)) u_dp (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cmd),
    .stat (stat),
    .req  (req),
    .res  (res),
    .cfg  (cfg)
  );

endmodule
`default_nettype wire

>>> tb/sv/tb_pss_channels.sv
// Testbench helper: request and result record types shared by driver, monitor and scoreboard.
package tb_pss_types;
  import pss_pkg::*;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic [ARR_W-1:0]          arrival;
    logic [BURST_W-1:0]        burst;
    logic signed [PRIO_W-1:0]  prio;
  } sched_req_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [IDX_W-1:0]  proc_index;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic              completed;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
  } slice_res_t;
endpackage

>>> tb/sv/tb_process_slice_scheduler.sv
// Testbench of the process slice scheduler: random load/step/clear traffic checked
// against an in-bench scheduling predictor, with random stalls on both channels.
module tb_process_slice_scheduler;
  timeunit 1ns;
  timeprecision 1ps;
  import pss_pkg::*;
  import tb_pss_types::*;

  localparam int NPROC = DEF_MAX_PROCS;
  localparam int WATCHDOG_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  pss_req_if req_ch();
  pss_res_if res_ch();
  pss_cfg_if cfg_ch();

  process_slice_scheduler #(.MAX_PROCS(NPROC)) u_dut (
    .clk(clk), .rst(rst), .req(req_ch.sink), .res(res_ch.source), .cfg(cfg_ch.sink)
  );

  always #5 clk = ~clk;

  // predicted scheduler state
  logic [ARR_W-1:0]         sim_arrival  [NPROC];
  logic [BURST_W-1:0]       sim_burst    [NPROC];
  logic [BURST_W-1:0]       sim_remain   [NPROC];
  logic signed [PRIO_W-1:0] sim_prio     [NPROC];
  logic [TIME_W-1:0]        sim_requeue  [NPROC];
  logic [NPROC-1:0]         sim_done;
  int                       sim_count;
  logic [TIME_W-1:0]        sim_now;
  logic                     sim_running;
  logic [MODE_W-1:0]        sim_mode;
  logic [QNT_W-1:0]         sim_quantum;

  sched_req_t pending_reqs[$];
  slice_res_t expected_slices[$];
  int  errors = 0;
  int  n_slices = 0, n_completions = 0, n_full = 0, n_done = 0, n_beats = 0;
  logic stim_done = 1'b0;
  logic hold_off_req = 1'b0;
  logic sender_pause = 1'b0;
  int   long_stall = 0;

  function automatic bit better(int a, int b, logic [MODE_W-1:0] m);
    case (m)
      MODE_SJF, MODE_SRTF: return sim_remain[a] < sim_remain[b];
      MODE_RR:             return sim_requeue[a] < sim_requeue[b];
      MODE_SPRIO, MODE_DPRIO: return sim_prio[a] > sim_prio[b];
      default:             return sim_arrival[a] < sim_arrival[b];
    endcase
  endfunction

  task automatic predict_slice(input sched_req_t r);
    slice_res_t o;
    logic [TIME_W-1:0] earliest, st, en, ta;
    logic [MODE_W-1:0] m;
    logic [31:0] run, q, endw;
    bit any_left, any_arr;
    int pick;
    o = '0;
    any_left = 0;
    any_arr = 0;
    earliest = '0;
    pick = -1;
    if (r.req_type == REQ_LOAD) begin
      if (sim_count >= NPROC) begin
        o.status = ST_FULL;
        n_full++;
      end else begin
        sim_arrival[sim_count] = r.arrival;
        sim_burst[sim_count]   = r.burst;
        sim_remain[sim_count]  = r.burst;
        sim_requeue[sim_count] = {1'b0, r.arrival};
        sim_prio[sim_count]    = r.prio;
        sim_done[sim_count]    = 1'b0;
        sim_count++;
        o.status = ST_OK;
      end
      expected_slices.push_back(o);
      return;
    end
    if (r.req_type == REQ_CLEAR) begin
      sim_done = '0;
      sim_count = 0;
      sim_now = '0;
      sim_running = 1'b0;
      o.status = ST_OK;
      expected_slices.push_back(o);
      return;
    end
    if (r.req_type != REQ_STEP) return;
    for (int i = 0; i < sim_count; i++) begin
      if (!sim_done[i]) begin
        if (!any_left || sim_arrival[i] < earliest) earliest = sim_arrival[i];
        any_left = 1;
      end
    end
    if (!any_left) begin
      o.status = ST_DONE;
      n_done++;
      expected_slices.push_back(o);
      return;
    end
    if (!sim_running) begin
      sim_now = earliest;
      sim_running = 1'b1;
    end
    for (int i = 0; i < sim_count; i++)
      if (!sim_done[i] && sim_arrival[i] <= sim_now) any_arr = 1;
    if (!any_arr) sim_now = earliest;
    m = (sim_mode > MODE_DPRIO) ? MODE_FCFS : sim_mode;
    for (int i = 0; i < sim_count; i++) begin
      if (sim_done[i] || sim_arrival[i] > sim_now) continue;
      if (pick < 0 || better(i, pick, m)) pick = i;
    end
    q = (sim_quantum == 0) ? 1 : sim_quantum;
    run = sim_remain[pick];
    if ((m == MODE_SRTF || m == MODE_RR || m == MODE_DPRIO) && run > q) run = q;
    st = sim_now;
    endw = st + run;
    en = (endw > TIME_LIMIT) ? TIME_LIMIT : endw[TIME_W-1:0];
    sim_now = en;
    sim_remain[pick] = sim_remain[pick] - run[BURST_W-1:0];
    o.status = ST_SLICE;
    o.proc_index = pick[IDX_W-1:0];
    o.start_time = st;
    o.end_time = en;
    n_slices++;
    if (sim_remain[pick] == 0) begin
      ta = en - sim_arrival[pick];
      sim_done[pick] = 1'b1;
      o.completed = 1'b1;
      o.turnaround = ta;
      o.waiting = (ta > sim_burst[pick]) ? ta - sim_burst[pick] : '0;
      n_completions++;
    end else begin
      if (m == MODE_RR) sim_requeue[pick] = en;
      if (m == MODE_DPRIO && sim_prio[pick] != -128) sim_prio[pick] = sim_prio[pick] - 1;
    end
    expected_slices.push_back(o);
  endtask

  // request driver
  int req_gap = 0;
  bit req_acc = 1'b0;
  always @(negedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && !req_acc) begin
      // hold the beat
    end else begin
      if (req_acc) begin
        req_acc = 1'b0;
        req_gap = $urandom_range(0, 3);
      end
      if (req_gap > 0 || sender_pause || pending_reqs.size() == 0) begin
        if (req_gap > 0) req_gap--;
        req_ch.valid <= 1'b0;
      end else begin
        req_ch.valid        <= 1'b1;
        req_ch.req_type     <= pending_reqs[0].req_type;
        req_ch.arrival      <= pending_reqs[0].arrival;
        req_ch.burst        <= pending_reqs[0].burst;
        req_ch.priority_req <= pending_reqs[0].prio;
      end
    end
  end

  // predict on each accepted request beat
  always @(posedge clk) begin
    if (!rst && req_ch.valid && req_ch.ready) begin
      predict_slice(pending_reqs.pop_front());
      req_acc = 1'b1;
      n_beats++;
    end
  end

  // result receiver
  int res_gap = 0;
  always @(negedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else if (long_stall > 0) begin
      long_stall--;
      res_ch.ready <= 1'b0;
    end else if (hold_off_req) begin
      long_stall = 60;
      res_ch.ready <= 1'b0;
    end else if (res_gap > 0) begin
      res_gap--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    slice_res_t got, want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      res_gap = $urandom_range(0, 3);
      got = '{res_ch.status, res_ch.proc_index, res_ch.start_time, res_ch.end_time,
              res_ch.completed, res_ch.turnaround, res_ch.waiting};
      if (expected_slices.size() == 0) begin
        $display("%0t: unexpected result beat %p", $time, got);
        errors++;
      end else begin
        want = expected_slices.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // watchdog on accepted beats
  int idle_cycles = 0;
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time,
               expected_slices.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic add_req(input logic [REQ_W-1:0] t, input logic [ARR_W-1:0] a,
                         input logic [BURST_W-1:0] b, input logic signed [PRIO_W-1:0] p);
    pending_reqs.push_back('{t, a, b, p});
  endtask

  task automatic drain();
    while (pending_reqs.size() != 0 || expected_slices.size() != 0) @(posedge clk);
    repeat (2 * NPROC + 8) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [CFG_D_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == REG_MODE) sim_mode = val[MODE_W-1:0];
    else sim_quantum = val;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // one batch: clear, load up to a full table plus one, then random steps mixed with rare loads and unassigned types
  task automatic add_batch(input int nload, input bit narrow);
    int steps;
    add_req(REQ_CLEAR, ARR_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom));
    for (int i = 0; i < nload; i++)
      add_req(REQ_LOAD, narrow ? ARR_W'($urandom_range(0, 40)) : ARR_W'($urandom),
              narrow ? BURST_W'($urandom_range(1, 12)) : BURST_W'($urandom_range(0, 4095)),
              PRIO_W'($urandom));
    steps = $urandom_range(4, 20);
    for (int i = 0; i < steps; i++) begin
      if ($urandom_range(0, 15) == 0)
        add_req(REQ_LOAD, ARR_W'($urandom_range(0, 60)), BURST_W'($urandom_range(1, 8)),
                PRIO_W'($urandom));
      else if ($urandom_range(0, 40) == 0)
        add_req(3, ARR_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom));
      else
        add_req(REQ_STEP, ARR_W'($urandom), BURST_W'($urandom), PRIO_W'($urandom));
    end
  endtask

  initial begin
    logic [MODE_W-1:0] modes[8];
    logic [QNT_W-1:0]  quanta[8];
    int phase_items;
    req_ch.valid = 1'b0;
    req_ch.req_type = '0;
    req_ch.arrival = '0;
    req_ch.burst = '0;
    req_ch.priority_req = '0;
    res_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    sim_done = '0;
    sim_count = 0;
    sim_now = '0;
    sim_running = 1'b0;
    sim_mode = MODE_FCFS;
    sim_quantum = 1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed: empty step, extremes, overflow, full table, unassigned type
    add_req(REQ_STEP, 0, 0, 0);
    add_req(REQ_LOAD, 16'hFFFF, 12'hFFF, 8'sd127);
    add_req(REQ_LOAD, 16'hFFFF, 12'hFFF, -8'sd128);
    add_req(REQ_LOAD, 16'hFFF0, 0, 8'sd0);
    add_req(REQ_LOAD, 0, 1, 8'sd5);
    add_req(REQ_LOAD, 100, 3, -8'sd1);
    add_req(REQ_LOAD, 200, 2, 8'sd5);
    add_req(REQ_LOAD, 0, 12'hAAA, 8'sh55);
    add_req(REQ_LOAD, 16'h5555, 12'h555, 8'shAA);
    add_req(REQ_LOAD, 1, 1, 0);
    add_req(3, 16'hFFFF, 12'hFFF, -8'sd1);
    for (int i = 0; i < 10; i++) add_req(REQ_STEP, 0, 0, 0);
    add_req(REQ_CLEAR, 0, 0, 0);
    add_req(REQ_STEP, 0, 0, 0);
    drain();

    modes  = '{MODE_DPRIO, MODE_RR, MODE_SRTF, MODE_SPRIO, MODE_SJF, 3'd7, MODE_FCFS, 3'd6};
    quanta = '{1, 4095, 2, 3, 0, 1, 5, 7};
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(REG_MODE, modes[ph]);
      write_reg(REG_QUANTUM, quanta[ph]);
      phase_items = 0;
      while (phase_items < 220) begin
        add_batch($urandom_range(1, 9), $urandom_range(0, 3) != 0);
        phase_items = phase_items + 20;
      end
      if (ph == 2) begin
        // long receiver hold-off while requests keep coming
        while (n_beats < 30 + phase_items) @(posedge clk);
        hold_off_req <= 1'b1;
        @(posedge clk);
        hold_off_req <= 1'b0;
      end
      if (ph == 4) begin
        while (pending_reqs.size() > 40) @(posedge clk);
        sender_pause <= 1'b1;
        while (expected_slices.size() != 0) @(posedge clk);
        sender_pause <= 1'b0;
      end
      drain();
    end

    stim_done = 1'b1;
    $display("Covered %0d request beats: %0d slices, %0d completions, %0d full, %0d all-done",
             n_beats, n_slices, n_completions, n_full, n_done);
    $display("across all six scheduling modes, unassigned modes and quantum extremes");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule
